@@ rtl/sps_pkg.sv @@
// Shared constants, types and helpers for the substring position search block.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int unsigned PAT_MAX  = 8;
  localparam int unsigned TEXT_MAX = 65536;
  localparam int unsigned CHAR_W   = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned PLEN_W   = 4;
  localparam int unsigned KIDX_W   = $clog2(PAT_MAX);
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_LAST = 3'd4;

  // Per-cycle command to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Per-transaction status to the controller: handshake, last flag and window hit
  typedef struct packed {
    logic accept;
    logic last;
    logic hit;
  } step_t;

  typedef struct packed {
    logic [PLEN_W-1:0] pat_len;
    logic [POS_W-1:0]  start_ofs;
    logic              find_last;
  } search_cfg_t;

  function automatic logic [CHAR_W-1:0] pat_char(input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [KIDX_W-1:0] k);
    logic [2*CFG_W-1:0] all;
    all = {hi, lo};
    return all[k*CHAR_W +: CHAR_W];
  endfunction

endpackage
`default_nettype wire

@@ rtl/sps_cell.sv @@
// One window cell: holds a text character, passes it on and compares with its pattern character.
`timescale 1ns / 1ps
`default_nettype none
module sps_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  sps_pkg::cell_ctl_t         ctl_i,
  input  wire                        active_i,
  input  wire [sps_pkg::CHAR_W-1:0]  pat_char_i,
  input  wire [sps_pkg::CHAR_W-1:0]  char_i,
  output logic [sps_pkg::CHAR_W-1:0] char_o,
  output logic                       hit_o
);
  import sps_pkg::*;

  logic [CHAR_W-1:0] char_q, char_d;

  // compare against the character being shifted in this cycle
  assign hit_o = !active_i || (char_i == pat_char_i);

  always_comb begin
    char_d = char_q;
    if (ctl_i.clear) begin
      char_d = '0;
    end else if (ctl_i.shift) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule
`default_nettype wire

@@ rtl/sps_ctrl.sv @@
// Character counter, match tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module sps_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  sps_pkg::step_t             step_i,
  input  sps_pkg::search_cfg_t       cfg_i,
  input  wire                        out_ready_i,
  output sps_pkg::cell_ctl_t         cell_ctl_o,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output logic [sps_pkg::OUT_W-1:0]  out_data_o
);
  import sps_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d, count_inc, pos;
  logic [POS_W-1:0]   idx_q, idx_d;
  logic               seen_q, seen_d, ovf_q, ovf_d;
  logic               full, advance, plen_ok, take, done;
  logic               found_next;
  logic               ovalid_q, ovalid_d;
  logic               ofound_q, oovf_q;
  logic [POS_W-1:0]   opos_q;

  assign in_ready_o = !ovalid_q || out_ready_i;

  assign full      = (count_q >= COUNT_W'(TEXT_MAX));
  assign advance   = step_i.accept && !full && !ovf_q;
  assign count_inc = count_q + COUNT_W'(1);
  assign pos       = count_inc - COUNT_W'(cfg_i.pat_len);
  assign plen_ok   = (cfg_i.pat_len != '0) && (cfg_i.pat_len <= PLEN_W'(PAT_MAX))
                     && (count_inc >= COUNT_W'(cfg_i.pat_len));
  assign take      = advance && plen_ok && (pos >= COUNT_W'(cfg_i.start_ofs))
                     && step_i.hit && (!seen_q || cfg_i.find_last);
  assign done      = step_i.accept && step_i.last;

  assign cell_ctl_o.shift = advance;
  assign cell_ctl_o.clear = done;

  always_comb begin
    ovf_d   = ovf_q || (step_i.accept && full);
    count_d = advance ? count_inc : count_q;
    idx_d   = take ? pos[POS_W-1:0] : idx_q;
    seen_d  = seen_q || take;
    found_next = seen_d && !ovf_d;
    if (done) begin
      count_d = '0;
      idx_d   = '0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (done) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      seen_q   <= 1'b0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      seen_q   <= seen_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      ofound_q <= found_next;
      opos_q   <= found_next ? (take ? pos[POS_W-1:0] : idx_q) : '0;
      oovf_q   <= ovf_q || (step_i.accept && full);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = {(OUT_W - POS_W - 2)'(0), oovf_q, opos_q, ofound_q};

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(TEXT_MAX))
    else $error("character count beyond text limit");

  a_seen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (count_q != '0))
    else $error("match recorded with no characters counted");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (count_q == '0) && !seen_q && !ovf_q && ovalid_q)
    else $error("per-text state not cleared at end of text");

  a_ovf_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oovf_q) |-> (!ofound_q && (opos_q == '0)))
    else $error("overflow result reports a match");

  a_nf_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ofound_q) |-> (opos_q == '0))
    else $error("non-zero position without a match");
`endif

endmodule
`default_nettype wire

@@ rtl/substring_position_search.sv @@
// Top level of the streaming substring position search.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata[15:0] text_char, tlast last_char
//  m_axis    out        tdata[0] found, [16:1] position, [17] overflow, [23:18] zero
//  cfg       in         cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per write
//
//  One character per cycle while s_axis_tready_o is high; the window cells compare
//  all pattern characters in the cycle the character shifts in. The result appears in
//  the cycle after the transaction marked last. The result register decouples the sides:
//  input is taken while the result is empty or being taken. Reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module substring_position_search (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire [sps_pkg::CHAR_W-1:0]    s_axis_tdata_i,  // text_char
  input  wire                          s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [sps_pkg::OUT_W-1:0]    m_axis_tdata_o,  // found, position, overflow, pad
  input  wire                          cfg_we_i,
  input  wire [sps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [sps_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import sps_pkg::*;

  logic [PLEN_W-1:0] pat_len_q;
  logic [CFG_W-1:0]  pat_lo_q, pat_hi_q;
  logic [POS_W-1:0]  start_ofs_q;
  logic              find_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      pat_lo_q    <= '0;
      pat_hi_q    <= '0;
      start_ofs_q <= '0;
      find_last_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LEN:   pat_len_q   <= cfg_wdata_i[PLEN_W-1:0];
        REG_PAT_LOW:   pat_lo_q    <= cfg_wdata_i;
        REG_PAT_HIGH:  pat_hi_q    <= cfg_wdata_i;
        REG_START_OFS: start_ofs_q <= cfg_wdata_i[POS_W-1:0];
        REG_FIND_LAST: find_last_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  search_cfg_t       cfg;
  cell_ctl_t         cell_ctl;
  step_t             step;
  logic [CHAR_W-1:0] chain [PAT_MAX+1];
  logic [PAT_MAX-1:0] hits;

  assign cfg.pat_len   = pat_len_q;
  assign cfg.start_ofs = start_ofs_q;
  assign cfg.find_last = find_last_q;

  assign chain[0] = s_axis_tdata_i;

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    logic [PLEN_W-1:0] k;
    logic              active;
    assign active = (PLEN_W'(i) < pat_len_q);
    assign k      = pat_len_q - PLEN_W'(1) - PLEN_W'(i);

    sps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl),
      .active_i   (active),
      .pat_char_i (pat_char(pat_lo_q, pat_hi_q, k[KIDX_W-1:0])),
      .char_i     (chain[i]),
      .char_o     (chain[i+1]),
      .hit_o      (hits[i])
    );
  end

  assign step.accept = s_axis_tvalid_i && s_axis_tready_o;
  assign step.last   = s_axis_tlast_i;
  assign step.hit    = &hits;

  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cfg_i       (cfg),
    .out_ready_i (m_axis_tready_i),
    .cell_ctl_o  (cell_ctl),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

@@ bench/tb_substring_position_search.sv @@
// Testbench for substring_position_search: stream driver, result monitor and scoreboard.
`timescale 1ns / 1ps
module tb_substring_position_search;
  import sps_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SHOW_MAX    = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_item_t;

  // packed to line up with tdata: found lowest, then position, then overflow
  typedef struct packed {
    logic             overflow;
    logic [POS_W-1:0] position;
    logic             found;
  } search_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [CHAR_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  substring_position_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // search model: registers and per-text state
  logic [PLEN_W-1:0] srch_len = '0;
  logic [CFG_W-1:0]  srch_lo = '0;
  logic [CFG_W-1:0]  srch_hi = '0;
  logic [POS_W-1:0]  srch_ofs = '0;
  logic              srch_last_mode = 1'b0;
  logic [CHAR_W-1:0] win [PAT_MAX];
  int unsigned       win_count = 0;
  logic [POS_W-1:0]  hit_pos = '0;
  logic              hit_seen = 1'b0;
  logic              text_ovf = 1'b0;

  search_result_t results_due[$];
  text_item_t     pending[$];
  logic [CHAR_W-1:0] txt[$];

  int unsigned chars_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  bit          src_taken = 1'b0;
  bit          idle_on = 1'b1;
  text_item_t  src_item;

  task automatic track_char(input logic [CHAR_W-1:0] ch, input logic last);
    logic [2*CFG_W-1:0] pat_all;
    int unsigned pos;
    bit hit;
    search_result_t res;
    pat_all = {srch_hi, srch_lo};
    if (win_count >= TEXT_MAX) begin
      text_ovf = 1'b1;
    end else if (!text_ovf) begin
      for (int i = PAT_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = ch;
      win_count++;
      if (srch_len != 0 && srch_len <= PAT_MAX && win_count >= srch_len) begin
        pos = win_count - srch_len;
        if (pos >= srch_ofs) begin
          hit = 1'b1;
          for (int k = 0; k < srch_len; k++) begin
            if (win[srch_len-1-k] != pat_all[k*CHAR_W +: CHAR_W]) hit = 1'b0;
          end
          if (hit && (!hit_seen || srch_last_mode)) begin
            hit_pos = pos[POS_W-1:0];
            hit_seen = 1'b1;
          end
        end
      end
    end
    if (last) begin
      res.overflow = text_ovf;
      res.found = text_ovf ? 1'b0 : hit_seen;
      res.position = (text_ovf || !hit_seen) ? '0 : hit_pos;
      results_due.push_back(res);
      foreach (win[i]) win[i] = '0;
      win_count = 0;
      hit_pos = '0;
      hit_seen = 1'b0;
      text_ovf = 1'b0;
    end
  endtask

  // source side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || src_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        src_item = pending.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= src_item.ch;
        s_axis_tlast_i <= src_item.last;
      end
    end
  end

  // sink side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(1, 19) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    src_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAT_LEN:   srch_len = cfg_wdata_i[PLEN_W-1:0];
          REG_PAT_LOW:   srch_lo = cfg_wdata_i;
          REG_PAT_HIGH:  srch_hi = cfg_wdata_i;
          REG_START_OFS: srch_ofs = cfg_wdata_i[POS_W-1:0];
          REG_FIND_LAST: srch_last_mode = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("unexpected result tdata=%h", m_axis_tdata_o);
        end else if (m_axis_tdata_o !== {{(OUT_W-18){1'b0}}, results_due[0]}) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("mismatch: exp found=%b pos=%0d ovf=%b, got found=%b pos=%0d ovf=%b pad=%h",
                     results_due[0].found, results_due[0].position, results_due[0].overflow,
                     m_axis_tdata_o[0], m_axis_tdata_o[16:1], m_axis_tdata_o[17],
                     m_axis_tdata_o[OUT_W-1:18]);
          void'(results_due.pop_front());
        end else begin
          void'(results_due.pop_front());
        end
      end
      if (src_taken) begin
        track_char(s_axis_tdata_i, s_axis_tlast_i);
        chars_taken++;
      end
      if (src_taken || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic set_search(input logic [PLEN_W-1:0] len, input logic [CFG_W-1:0] lo,
                            input logic [CFG_W-1:0] hi, input logic [POS_W-1:0] ofs,
                            input logic fl);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PAT_LEN;
    cfg_wdata_i <= CFG_W'(len);
    @(negedge clk_i);
    cfg_idx_i <= REG_PAT_LOW;
    cfg_wdata_i <= lo;
    @(negedge clk_i);
    cfg_idx_i <= REG_PAT_HIGH;
    cfg_wdata_i <= hi;
    @(negedge clk_i);
    cfg_idx_i <= REG_START_OFS;
    cfg_wdata_i <= CFG_W'(ofs);
    @(negedge clk_i);
    cfg_idx_i <= REG_FIND_LAST;
    cfg_wdata_i <= CFG_W'(fl);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_text();
    text_item_t it;
    foreach (txt[i]) begin
      it.ch = txt[i];
      it.last = (i == txt.size() - 1);
      pending.push_back(it);
    end
    chars_queued += txt.size();
    txt.delete();
  endtask

  // block idle: all characters taken, all results back, plus the output latency
  task automatic wait_drained();
    while (chars_taken != chars_queued || results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [CHAR_W-1:0] alpha [3];
    logic [CHAR_W-1:0] pat [PAT_MAX];
    logic [PLEN_W-1:0] plen;
    logic [POS_W-1:0]  ofs;
    int unsigned n;
    int unsigned len;
    foreach (win[i]) win[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first match, short text, last match past the offset
    set_search(4'd3, 64'h0000_0043_0042_0041, 64'h0, 16'd0, 1'b0);
    txt = '{16'h0041, 16'h0042, 16'h0043, 16'h0041, 16'h0042, 16'h0043};
    send_text();
    txt = '{16'h0041, 16'h0042};
    send_text();
    wait_drained();
    set_search(4'd3, 64'h0000_0043_0042_0041, 64'h0, 16'd1, 1'b1);
    txt = '{16'h0041, 16'h0042, 16'h0043, 16'h0041, 16'h0042, 16'h0043};
    send_text();
    wait_drained();
    // full-length pattern of all ones
    set_search(4'd8, '1, '1, 16'd0, 1'b0);
    repeat (8) txt.push_back(16'hFFFF);
    send_text();
    wait_drained();
    // pattern too long, then a one-character text
    set_search(4'd9, 64'h0, 64'h0, 16'd0, 1'b0);
    txt = '{16'h0000, 16'h0000};
    send_text();
    wait_drained();
    set_search(4'd1, 64'h0, 64'h0, 16'd0, 1'b0);
    txt = '{16'h0000};
    send_text();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph < 6);
      if (ph == 0) plen = 4'd0;
      else if (ph == 1) plen = 4'd15;
      else if ($urandom_range(0, 9) < 8) plen = PLEN_W'($urandom_range(1, PAT_MAX));
      else plen = PLEN_W'($urandom_range(9, 15));
      foreach (alpha[a]) begin
        case ($urandom_range(0, 5))
          0: alpha[a] = 16'h0000;
          1: alpha[a] = 16'hFFFF;
          default: alpha[a] = CHAR_W'($urandom_range(0, 65535));
        endcase
      end
      foreach (pat[k])
        pat[k] = (k < plen) ? alpha[$urandom_range(0, 2)] : CHAR_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
        0: ofs = 16'd0;
        4: ofs = POS_W'($urandom_range(0, 65535));
        5: ofs = 16'hFFFF;
        default: ofs = POS_W'($urandom_range(0, 10));
      endcase
      set_search(plen, {pat[3], pat[2], pat[1], pat[0]}, {pat[7], pat[6], pat[5], pat[4]},
                 ofs, 1'($urandom_range(0, 1)));
      n = 0;
      while (n < 50) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        while (txt.size() < len) begin
          if (plen != 0 && plen <= PAT_MAX && $urandom_range(0, 3) == 0) begin
            for (int k = 0; k < plen; k++) txt.push_back(pat[k]);
          end else if ($urandom_range(0, 4) == 0) begin
            txt.push_back(CHAR_W'($urandom_range(0, 65535)));
          end else begin
            txt.push_back(alpha[$urandom_range(0, 2)]);
          end
        end
        n += txt.size();
        send_text();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
